@@ hw/rtl/larm_pkg.sv @@
package larm_pkg;

	localparam int COORD_W = 32;
	localparam int DIFF_W = COORD_W + 1;
	localparam int MAG_W = DIFF_W;
	localparam int NORM_W = 30;
	localparam int NORM_STEPS = 5;
	localparam int NORM_FIRST_SH = 16;
	localparam int VEC_W = NORM_W + 2;
	localparam int SUM_W = 2 * NORM_W + 4;
	localparam int ROOT_W = NORM_W + 1;
	localparam int DIV_W = 2 * NORM_W + 2;
	localparam int Q_W = NORM_W + 1;
	localparam int PROD_W = 2 * VEC_W;
	localparam int OUT_W = 16;
	localparam logic [PROD_W-1:0] NEG_MAX = PROD_W'(1) << (OUT_W - 1);
	localparam logic [PROD_W-1:0] POS_MAX = NEG_MAX - PROD_W'(1);

	typedef logic signed [DIFF_W-1:0] diff_t;
	typedef diff_t [2:0] tri_diff_t;
	typedef logic [2:0][MAG_W-1:0] tri_mag_t;
	typedef logic [2:0][NORM_W-1:0] tri_norm_t;
	typedef logic [2:0][DIV_W-1:0] tri_div_t;
	typedef logic [2:0][Q_W-1:0] tri_q_t;
	typedef logic signed [VEC_W-1:0] vec_t;
	typedef vec_t [2:0] tri_vec_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] camera_x;
		logic signed [COORD_W-1:0] camera_y;
		logic signed [COORD_W-1:0] camera_z;
		logic signed [COORD_W-1:0] target_x;
		logic signed [COORD_W-1:0] target_y;
		logic signed [COORD_W-1:0] target_z;
	} larm_in_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] m0;
		logic signed [OUT_W-1:0] m1;
		logic signed [OUT_W-1:0] m2;
		logic signed [OUT_W-1:0] m3;
		logic signed [OUT_W-1:0] m4;
		logic signed [OUT_W-1:0] m5;
		logic signed [OUT_W-1:0] m6;
		logic signed [OUT_W-1:0] m7;
		logic signed [OUT_W-1:0] m8;
		logic degenerate;
	} larm_out_t;

endpackage

@@ hw/rtl/larm_stream_if.sv @@
interface larm_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

@@ hw/rtl/larm_sqrt_cell.sv @@
module larm_sqrt_cell import larm_pkg::*; #(
	parameter int BIT = 0,
	parameter int SIDE_W = 1
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic vld_i,
	input logic [SUM_W-1:0] rem_i,
	input logic [ROOT_W-1:0] root_i,
	input logic [SIDE_W-1:0] side_i,
	output logic vld_o,
	output logic [SUM_W-1:0] rem_o,
	output logic [ROOT_W-1:0] root_o,
	output logic [SIDE_W-1:0] side_o
);

	logic vld_q;
	logic [SUM_W-1:0] rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [SIDE_W-1:0] side_q;
	logic [SUM_W-1:0] trial;
	logic take;

	// (root + 2^BIT)^2 - root^2 = root * 2^(BIT+1) + 2^(2*BIT)
	assign trial = (SUM_W'(root_i) << (BIT + 1)) + (SUM_W'(1) << (2 * BIT));
	assign take = rem_i >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q <= take ? rem_i - trial : rem_i;
			root_q <= take ? (root_i | (ROOT_W'(1) << BIT)) : root_i;
			side_q <= side_i;
		end
	end

	assign vld_o = vld_q;
	assign rem_o = rem_q;
	assign root_o = root_q;
	assign side_o = side_q;

endmodule

@@ hw/rtl/larm_div_cell.sv @@
module larm_div_cell import larm_pkg::*; #(
	parameter int BIT = 0,
	parameter int SIDE_W = 1
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic vld_i,
	input tri_div_t rem_i,
	input tri_q_t q_i,
	input logic [ROOT_W-1:0] dvs_i,
	input logic [SIDE_W-1:0] side_i,
	output logic vld_o,
	output tri_div_t rem_o,
	output tri_q_t q_o,
	output logic [ROOT_W-1:0] dvs_o,
	output logic [SIDE_W-1:0] side_o
);

	logic vld_q;
	tri_div_t rem_q;
	tri_q_t q_q;
	logic [ROOT_W-1:0] dvs_q;
	logic [SIDE_W-1:0] side_q;
	logic [DIV_W-1:0] step;

	assign step = DIV_W'(dvs_i) << BIT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_i;
		end
	end

	// one quotient bit for each of the three lanes
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				if (rem_i[i] >= step) begin
					rem_q[i] <= rem_i[i] - step;
					q_q[i] <= q_i[i] | (Q_W'(1) << BIT);
				end else begin
					rem_q[i] <= rem_i[i];
					q_q[i] <= q_i[i];
				end
			end
			dvs_q <= dvs_i;
			side_q <= side_i;
		end
	end

	assign vld_o = vld_q;
	assign rem_o = rem_q;
	assign q_o = q_q;
	assign dvs_o = dvs_q;
	assign side_o = side_q;

endmodule

@@ hw/rtl/larm_unit.sv @@
module larm_unit import larm_pkg::*; #(
	parameter int SIDE_W = 1
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic vld_i,
	input tri_diff_t vec_i,
	input logic [SIDE_W-1:0] side_i,
	output logic vld_o,
	output tri_vec_t unit_o,
	output logic ok_o,
	output logic [SIDE_W-1:0] side_o
);

	localparam int SQ_SIDE_W = 3 * NORM_W + 3 + 1 + SIDE_W;
	localparam int DV_SIDE_W = 3 + 1 + SIDE_W;

	// magnitudes and the largest of them
	tri_mag_t mag_in;
	logic [MAG_W-1:0] top_in;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag_in[i] = vec_i[i][DIFF_W-1] ? MAG_W'(-vec_i[i]) : MAG_W'(vec_i[i]);
		end
		top_in = mag_in[0];
		if (mag_in[1] > top_in) begin
			top_in = mag_in[1];
		end
		if (mag_in[2] > top_in) begin
			top_in = mag_in[2];
		end
	end

	logic vld_s1;
	tri_mag_t mag_s1;
	logic [MAG_W-1:0] top_s1;
	logic [2:0] neg_s1;
	logic [SIDE_W-1:0] side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1 <= mag_in;
			top_s1 <= top_in;
			for (int i = 0; i < 3; i++) begin
				neg_s1[i] <= vec_i[i][DIFF_W-1];
			end
			side_s1 <= side_i;
		end
	end

	// block scaling: bring the top magnitude into [2^29, 2^30)
	logic [1:0] rsh;

	always_comb begin
		if (top_s1[MAG_W-1]) begin
			rsh = 2'd3;
		end else if (top_s1[MAG_W-2]) begin
			rsh = 2'd2;
		end else if (top_s1[MAG_W-3]) begin
			rsh = 2'd1;
		end else begin
			rsh = 2'd0;
		end
	end

	logic nrm_vld_s [NORM_STEPS+1];
	tri_norm_t nrm_mag_s [NORM_STEPS+1];
	logic [NORM_W-1:0] nrm_top_s [NORM_STEPS+1];
	logic [2:0] nrm_neg_s [NORM_STEPS+1];
	logic nrm_zero_s [NORM_STEPS+1];
	logic [SIDE_W-1:0] nrm_side_s [NORM_STEPS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nrm_vld_s[0] <= 1'b0;
		end else if (en) begin
			nrm_vld_s[0] <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				nrm_mag_s[0][i] <= NORM_W'(mag_s1[i] >> rsh);
			end
			nrm_top_s[0] <= NORM_W'(top_s1 >> rsh);
			nrm_neg_s[0] <= neg_s1;
			nrm_zero_s[0] <= top_s1 == '0;
			nrm_side_s[0] <= side_s1;
		end
	end

	for (genvar k = 0; k < NORM_STEPS; k++) begin : g_nrm
		localparam int SH = NORM_FIRST_SH >> k;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				nrm_vld_s[k+1] <= 1'b0;
			end else if (en) begin
				nrm_vld_s[k+1] <= nrm_vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (nrm_top_s[k][NORM_W-1 -: SH] == '0) begin
					nrm_top_s[k+1] <= nrm_top_s[k] << SH;
					for (int i = 0; i < 3; i++) begin
						nrm_mag_s[k+1][i] <= nrm_mag_s[k][i] << SH;
					end
				end else begin
					nrm_top_s[k+1] <= nrm_top_s[k];
					nrm_mag_s[k+1] <= nrm_mag_s[k];
				end
				nrm_neg_s[k+1] <= nrm_neg_s[k];
				nrm_zero_s[k+1] <= nrm_zero_s[k];
				nrm_side_s[k+1] <= nrm_side_s[k];
			end
		end
	end

	// squares, then their sum
	logic vld_s8;
	logic [2*NORM_W-1:0] sq_s8 [3];
	tri_norm_t mag_s8;
	logic [2:0] neg_s8;
	logic zero_s8;
	logic [SIDE_W-1:0] side_s8;

	logic vld_s9;
	logic [SUM_W-1:0] sum_s9;
	tri_norm_t mag_s9;
	logic [2:0] neg_s9;
	logic zero_s9;
	logic [SIDE_W-1:0] side_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else if (en) begin
			vld_s8 <= nrm_vld_s[NORM_STEPS];
			vld_s9 <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s8[i] <= nrm_mag_s[NORM_STEPS][i] * nrm_mag_s[NORM_STEPS][i];
			end
			mag_s8 <= nrm_mag_s[NORM_STEPS];
			neg_s8 <= nrm_neg_s[NORM_STEPS];
			zero_s8 <= nrm_zero_s[NORM_STEPS];
			side_s8 <= nrm_side_s[NORM_STEPS];

			sum_s9 <= SUM_W'(sq_s8[0]) + SUM_W'(sq_s8[1]) + SUM_W'(sq_s8[2]);
			mag_s9 <= mag_s8;
			neg_s9 <= neg_s8;
			zero_s9 <= zero_s8;
			side_s9 <= side_s8;
		end
	end

	// square root, one result bit per cell
	logic sq_vld [ROOT_W+1];
	logic [SUM_W-1:0] sq_rem [ROOT_W+1];
	logic [ROOT_W-1:0] sq_root [ROOT_W+1];
	logic [SQ_SIDE_W-1:0] sq_side [ROOT_W+1];

	assign sq_vld[0] = vld_s9;
	assign sq_rem[0] = sum_s9;
	assign sq_root[0] = '0;
	assign sq_side[0] = {mag_s9, neg_s9, zero_s9, side_s9};

	for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
		larm_sqrt_cell #(
			.BIT(ROOT_W - 1 - j),
			.SIDE_W(SQ_SIDE_W)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.vld_i(sq_vld[j]),
			.rem_i(sq_rem[j]),
			.root_i(sq_root[j]),
			.side_i(sq_side[j]),
			.vld_o(sq_vld[j+1]),
			.rem_o(sq_rem[j+1]),
			.root_o(sq_root[j+1]),
			.side_o(sq_side[j+1])
		);
	end

	tri_norm_t mag_r;
	logic [2:0] neg_r;
	logic zero_r;
	logic [SIDE_W-1:0] side_r;

	assign {mag_r, neg_r, zero_r, side_r} = sq_side[ROOT_W];

	// rounded division of each magnitude by the length
	logic dv_vld [Q_W+1];
	tri_div_t dv_rem [Q_W+1];
	tri_q_t dv_q [Q_W+1];
	logic [ROOT_W-1:0] dv_dvs [Q_W+1];
	logic [DV_SIDE_W-1:0] dv_side [Q_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_vld[0] <= 1'b0;
		end else if (en) begin
			dv_vld[0] <= sq_vld[ROOT_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				dv_rem[0][i] <= (DIV_W'(mag_r[i]) << NORM_W) + DIV_W'(sq_root[ROOT_W] >> 1);
			end
			dv_q[0] <= '0;
			dv_dvs[0] <= sq_root[ROOT_W];
			dv_side[0] <= {neg_r, zero_r, side_r};
		end
	end

	for (genvar j = 0; j < Q_W; j++) begin : g_div
		larm_div_cell #(
			.BIT(Q_W - 1 - j),
			.SIDE_W(DV_SIDE_W)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.vld_i(dv_vld[j]),
			.rem_i(dv_rem[j]),
			.q_i(dv_q[j]),
			.dvs_i(dv_dvs[j]),
			.side_i(dv_side[j]),
			.vld_o(dv_vld[j+1]),
			.rem_o(dv_rem[j+1]),
			.q_o(dv_q[j+1]),
			.dvs_o(dv_dvs[j+1]),
			.side_o(dv_side[j+1])
		);
	end

	logic [2:0] neg_d;
	logic zero_d;
	logic [SIDE_W-1:0] side_d;

	assign {neg_d, zero_d, side_d} = dv_side[Q_W];

	logic vld_q;
	tri_vec_t unit_q;
	logic ok_q;
	logic [SIDE_W-1:0] side_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= dv_vld[Q_W];
		end
	end

	// a zero vector passes through as zero
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				if (zero_d) begin
					unit_q[i] <= '0;
				end else if (neg_d[i]) begin
					unit_q[i] <= -VEC_W'(dv_q[Q_W][i]);
				end else begin
					unit_q[i] <= VEC_W'(dv_q[Q_W][i]);
				end
			end
			ok_q <= !zero_d;
			side_q <= side_d;
		end
	end

	assign vld_o = vld_q;
	assign unit_o = unit_q;
	assign ok_o = ok_q;
	assign side_o = side_q;

endmodule

@@ hw/rtl/look_at_rotation_matrix_top.sv @@
// Look-at rotation matrix: takes a camera point and a target point (signed Q16.16) and returns
// the 3x3 look-at basis in signed Q2.14 with a degenerate flag. The block is fully pipelined
// and takes one transaction per cycle whenever the pipeline is not held. It is made of the two
// normalizers in series, each a chain of 31 square-root cells and 31 divider cells, plus
// scaling, cross product and rounding stages. The whole pipeline holds only while the output
// register has a result that the sink has not taken and the last stage has another result
// waiting behind it.
module look_at_rotation_matrix_top import larm_pkg::*; #(
	parameter int OUT_FRAC_BITS = 14
) (
	input logic clk,
	input logic arst_n,
	larm_stream_if.sink pos,
	larm_stream_if.source mat
);

	localparam int US = NORM_W - OUT_FRAC_BITS;
	localparam int PS = 2 * NORM_W - OUT_FRAC_BITS;
	localparam logic [PROD_W-1:0] LIM = PROD_W'(1) << OUT_FRAC_BITS;
	localparam int R_SIDE_W = 3 * VEC_W + 1;

	function automatic logic signed [PROD_W-1:0] ext64(input logic [VEC_W-1:0] x);
		return {{(PROD_W - VEC_W){x[VEC_W-1]}}, x};
	endfunction

	// round half away from zero, then clamp the magnitude
	function automatic logic [OUT_W-1:0] to_out(input logic signed [PROD_W-1:0] v,
			input int unsigned sh);
		logic [PROD_W-1:0] m;
		logic [PROD_W-1:0] r;
		m = v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
		m = (m + ((PROD_W'(1) << sh) >> 1)) >> sh;
		if (m > LIM) begin
			m = LIM;
		end
		if (v[PROD_W-1]) begin
			if (m > NEG_MAX) begin
				m = NEG_MAX;
			end
		end else if (m > POS_MAX) begin
			m = POS_MAX;
		end
		r = v[PROD_W-1] ? -m : m;
		return r[OUT_W-1:0];
	endfunction

	logic en;
	logic up_vld_s3;
	logic out_vld_q;
	larm_out_t out_q;

	assign en = !out_vld_q || mat.ready || !up_vld_s3;
	assign pos.ready = en;

	// exact 33-bit differences
	logic vld_s1;
	tri_diff_t dif_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= pos.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dif_s1[0] <= {pos.data.target_x[COORD_W-1], pos.data.target_x}
				- {pos.data.camera_x[COORD_W-1], pos.data.camera_x};
			dif_s1[1] <= {pos.data.target_y[COORD_W-1], pos.data.target_y}
				- {pos.data.camera_y[COORD_W-1], pos.data.camera_y};
			dif_s1[2] <= {pos.data.target_z[COORD_W-1], pos.data.target_z}
				- {pos.data.camera_z[COORD_W-1], pos.data.camera_z};
		end
	end

	// forward
	logic f_vld;
	tri_vec_t f_unit;
	logic f_ok;

	larm_unit #(
		.SIDE_W(1)
	) u_fwd (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.vld_i(vld_s1),
		.vec_i(dif_s1),
		.side_i(1'b0),
		.vld_o(f_vld),
		.unit_o(f_unit),
		.ok_o(f_ok),
		.side_o()
	);

	// right = up_world x forward = (fz, 0, -fx)
	tri_diff_t cr_vec;

	assign cr_vec[0] = {f_unit[2][VEC_W-1], f_unit[2]};
	assign cr_vec[1] = '0;
	assign cr_vec[2] = -{f_unit[0][VEC_W-1], f_unit[0]};

	logic r_vld;
	tri_vec_t r_unit;
	logic r_ok;
	logic [R_SIDE_W-1:0] r_side;

	larm_unit #(
		.SIDE_W(R_SIDE_W)
	) u_right (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.vld_i(f_vld),
		.vec_i(cr_vec),
		.side_i({f_ok, f_unit}),
		.vld_o(r_vld),
		.unit_o(r_unit),
		.ok_o(r_ok),
		.side_o(r_side)
	);

	tri_vec_t f_dly;
	logic f_ok_dly;

	assign {f_ok_dly, f_dly} = r_side;

	// up = forward x right
	vec_t fa0, fa1, fa2, ra0, ra1, ra2;

	assign fa0 = f_dly[0];
	assign fa1 = f_dly[1];
	assign fa2 = f_dly[2];
	assign ra0 = r_unit[0];
	assign ra1 = r_unit[1];
	assign ra2 = r_unit[2];

	logic prd_vld_s2;
	logic signed [PROD_W-1:0] pa_s2 [3];
	logic signed [PROD_W-1:0] pb_s2 [3];
	tri_vec_t f_s2;
	tri_vec_t r_s2;
	logic deg_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prd_vld_s2 <= 1'b0;
			up_vld_s3 <= 1'b0;
		end else if (en) begin
			prd_vld_s2 <= r_vld;
			up_vld_s3 <= prd_vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pa_s2[0] <= fa1 * ra2;
			pb_s2[0] <= fa2 * ra1;
			pa_s2[1] <= fa2 * ra0;
			pb_s2[1] <= fa0 * ra2;
			pa_s2[2] <= fa0 * ra1;
			pb_s2[2] <= fa1 * ra0;
			f_s2 <= f_dly;
			r_s2 <= r_unit;
			deg_s2 <= !(f_ok_dly && r_ok);
		end
	end

	logic signed [PROD_W-1:0] up_s3 [3];
	tri_vec_t f_s3;
	tri_vec_t r_s3;
	logic deg_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				up_s3[i] <= pa_s2[i] - pb_s2[i];
			end
			f_s3 <= f_s2;
			r_s3 <= r_s2;
			deg_s3 <= deg_s2;
		end
	end

	larm_out_t out_d;

	always_comb begin
		out_d.m0 = to_out(-ext64(r_s3[0]), US);
		out_d.m1 = to_out(up_s3[0], PS);
		out_d.m2 = to_out(-ext64(f_s3[0]), US);
		out_d.m3 = to_out(ext64(r_s3[1]), US);
		out_d.m4 = to_out(up_s3[1], PS);
		out_d.m5 = to_out(-ext64(f_s3[1]), US);
		out_d.m6 = to_out(-ext64(r_s3[2]), US);
		out_d.m7 = to_out(up_s3[2], PS);
		out_d.m8 = to_out(-ext64(f_s3[2]), US);
		out_d.degenerate = deg_s3;
	end

	// output register: load when a result arrives, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en && up_vld_s3) begin
			out_vld_q <= 1'b1;
		end else if (mat.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en && up_vld_s3) begin
			out_q <= out_d;
		end
	end

	assign mat.valid = out_vld_q;
	assign mat.data = out_q;

endmodule

@@ verif/tb_look_at_rotation_matrix_top.sv @@
module tb_look_at_rotation_matrix_top;
	import larm_pkg::*;

	localparam int UNIT_SH = 30;
	localparam int FRAC_OUT = 14;
	localparam int LATENCY = 150;

	logic clk;
	logic arst_n;
	bit steady;
	int mismatch_count;
	larm_out_t basis_queue[$];

	larm_stream_if #(.T(larm_in_t)) pos();
	larm_stream_if #(.T(larm_out_t)) mat();

	look_at_rotation_matrix_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.pos(pos),
		.mat(mat)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#3000000;
		$display("look_at_rotation_matrix_top test failed");
		$finish;
	end

	function automatic longint unsigned isqrt_u64(longint unsigned s);
		longint unsigned res = 0;
		longint unsigned b = 64'h1 << 62;
		while (b > s) b >>= 2;
		while (b != 0) begin
			if (s >= res + b) begin
				s -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	// Scale the magnitudes into [2^29, 2^30), then divide by the rounded-down length.
	function automatic bit unit_q30(input longint v[3], output longint u[3]);
		longint unsigned m[3];
		longint unsigned top = 0;
		longint unsigned s = 0;
		longint unsigned len;
		longint unsigned q;
		for (int i = 0; i < 3; i++) begin
			m[i] = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
			if (m[i] > top) top = m[i];
		end
		if (top == 0) begin
			for (int i = 0; i < 3; i++) u[i] = 0;
			return 1'b0;
		end
		while (top >= (64'h1 << UNIT_SH)) begin
			top >>= 1;
			for (int i = 0; i < 3; i++) m[i] >>= 1;
		end
		while (top < (64'h1 << (UNIT_SH - 1))) begin
			top <<= 1;
			for (int i = 0; i < 3; i++) m[i] <<= 1;
		end
		for (int i = 0; i < 3; i++) s += m[i] * m[i];
		len = isqrt_u64(s);
		for (int i = 0; i < 3; i++) begin
			q = ((m[i] << UNIT_SH) + (len >> 1)) / len;
			u[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
		end
		return 1'b1;
	endfunction

	// Round half away from zero, clamp to one and to the 16-bit range.
	function automatic logic [OUT_W-1:0] round_entry(longint v, int sh);
		longint unsigned m;
		m = (v < 0) ? longint'(-v) : longint'(v);
		if (sh > 0) m = (m + (64'h1 << (sh - 1))) >> sh;
		if (m > (64'h1 << FRAC_OUT)) m = 64'h1 << FRAC_OUT;
		if (v < 0 && m > 32768) m = 32768;
		if (v >= 0 && m > 32767) m = 32767;
		return (v < 0) ? OUT_W'(-longint'(m)) : OUT_W'(m);
	endfunction

	function automatic larm_out_t predict_basis(larm_in_t it);
		longint d[3], f[3], c[3], r[3], up[3];
		bit okf, okr;
		larm_out_t o;
		int us, ps;
		us = UNIT_SH - FRAC_OUT;
		ps = 2 * UNIT_SH - FRAC_OUT;
		d[0] = longint'(it.target_x) - longint'(it.camera_x);
		d[1] = longint'(it.target_y) - longint'(it.camera_y);
		d[2] = longint'(it.target_z) - longint'(it.camera_z);
		okf = unit_q30(d, f);
		c[0] = f[2];
		c[1] = 0;
		c[2] = -f[0];
		okr = unit_q30(c, r);
		up[0] = f[1] * r[2] - f[2] * r[1];
		up[1] = f[2] * r[0] - f[0] * r[2];
		up[2] = f[0] * r[1] - f[1] * r[0];
		o.m0 = round_entry(-r[0], us);
		o.m1 = round_entry(up[0], ps);
		o.m2 = round_entry(-f[0], us);
		o.m3 = round_entry(r[1], us);
		o.m4 = round_entry(up[1], ps);
		o.m5 = round_entry(-f[1], us);
		o.m6 = round_entry(-r[2], us);
		o.m7 = round_entry(up[2], ps);
		o.m8 = round_entry(-f[2], us);
		o.degenerate = !(okf && okr);
		return o;
	endfunction

	always @(posedge clk) begin
		mat.ready <= steady || ($urandom_range(99) >= 33);
	end

	function automatic void check_entry(string name, logic [OUT_W-1:0] want,
		logic [OUT_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name,
				$signed(want), $signed(got));
			mismatch_count++;
		end
	endfunction

	always @(posedge clk) begin
		larm_out_t want;
		larm_out_t got;
		if (arst_n && mat.valid && mat.ready) begin
			got = mat.data;
			if (basis_queue.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				mismatch_count++;
			end else begin
				want = basis_queue.pop_front();
				check_entry("m0", want.m0, got.m0);
				check_entry("m1", want.m1, got.m1);
				check_entry("m2", want.m2, got.m2);
				check_entry("m3", want.m3, got.m3);
				check_entry("m4", want.m4, got.m4);
				check_entry("m5", want.m5, got.m5);
				check_entry("m6", want.m6, got.m6);
				check_entry("m7", want.m7, got.m7);
				check_entry("m8", want.m8, got.m8);
				check_entry("degenerate", OUT_W'(want.degenerate), OUT_W'(got.degenerate));
			end
		end
	end

	task automatic send_points(larm_in_t it);
		if (!steady) begin
			while ($urandom_range(99) < 33) begin
				pos.valid <= 1'b0;
				@(posedge clk);
			end
		end
		pos.valid <= 1'b1;
		pos.data <= it;
		@(posedge clk);
		while (!pos.ready) @(posedge clk);
		basis_queue.push_back(predict_basis(it));
	endtask

	function automatic larm_in_t make_points(int ca_x, int ca_y, int ca_z,
		int ta_x, int ta_y, int ta_z);
		larm_in_t it;
		it.camera_x = ca_x;
		it.camera_y = ca_y;
		it.camera_z = ca_z;
		it.target_x = ta_x;
		it.target_y = ta_y;
		it.target_z = ta_z;
		return it;
	endfunction

	function automatic int rand_coord(int scale_sel);
		case (scale_sel)
			0: return int'($urandom);
			1: return int'($urandom_range(8191)) - 4096;
			2: return int'($urandom_range(1 << 20)) - (1 << 19);
			default: return ($urandom_range(1) != 0) ? 32'h7fffffff - int'($urandom_range(15))
				: 32'h80000000 + int'($urandom_range(15));
		endcase
	endfunction

	function automatic larm_in_t rand_points();
		larm_in_t it;
		int sel;
		sel = $urandom_range(3);
		it.camera_x = rand_coord(sel);
		it.camera_y = rand_coord(sel);
		it.camera_z = rand_coord(sel);
		it.target_x = rand_coord($urandom_range(3));
		it.target_y = rand_coord($urandom_range(3));
		it.target_z = rand_coord($urandom_range(3));
		case ($urandom_range(19))
			0: it.target_x = it.camera_x;
			1: it.target_z = it.camera_z;
			2: begin
				// vertical look, x and z identical
				it.target_x = it.camera_x;
				it.target_z = it.camera_z;
			end
			3: begin
				// nearly vertical, horizontal part lost in the scaling
				it.camera_y = 32'h80000000;
				it.target_y = 32'h7fffffff;
				it.target_x = it.camera_x + int'($urandom_range(2));
				it.target_z = it.camera_z - int'($urandom_range(2));
			end
			4: it = make_points(it.camera_x, it.camera_y, it.camera_z,
				it.camera_x, it.camera_y, it.camera_z);
			default: ;
		endcase
		return it;
	endfunction

	task automatic wait_drained();
		int guard;
		guard = 0;
		while (basis_queue.size() != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
	endtask

	task automatic test_directed();
		int mx, mn;
		mx = 32'h7fffffff;
		mn = 32'h80000000;
		send_points(make_points(0, 0, 0, 0, 0, 0));
		send_points(make_points(mx, mn, 5, mx, mn, 5));
		send_points(make_points(0, 0, 0, 0, 65536, 0));
		send_points(make_points(0, 0, 0, 0, -65536, 0));
		send_points(make_points(7, mn, -3, 7, mx, -3));
		send_points(make_points(0, mn, 0, 1, mx, -1));
		send_points(make_points(0, mx, 0, 0, mn, 1));
		send_points(make_points(0, 0, 0, 65536, 0, 0));
		send_points(make_points(0, 0, 0, -65536, 0, 0));
		send_points(make_points(0, 0, 0, 0, 0, 65536));
		send_points(make_points(0, 0, 0, 0, 0, -65536));
		send_points(make_points(mn, mn, mn, mx, mx, mx));
		send_points(make_points(mx, mx, mx, mn, mn, mn));
		send_points(make_points(mn, mx, mn, mx, mn, mx));
		send_points(make_points(0, 0, 0, 1, 1, 1));
		send_points(make_points(0, 0, 0, -1, 0, 1));
		send_points(make_points(1, 2, 3, 2, 2, 3));
		send_points(make_points(mx, 0, mn, mn, 0, mx));
		send_points(make_points(-65536, 0, 0, 65536, 65536, 65536));
		send_points(make_points(0, 0, 0, 3, 4, 0));
		send_points(make_points(0, 0, 0, 1, mx, 1));
	endtask

	task automatic test_random(int count);
		for (int i = 0; i < count; i++) send_points(rand_points());
	endtask

	task automatic test_no_idle(int count);
		steady = 1'b1;
		test_random(count);
		steady = 1'b0;
	endtask

	task automatic test_pause_until_drained(int count);
		test_random(count);
		pos.valid <= 1'b0;
		wait_drained();
		test_random(count);
	endtask

	initial begin
		arst_n = 1'b0;
		steady = 1'b0;
		mismatch_count = 0;
		pos.valid = 1'b0;
		pos.data = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(250);
		test_no_idle(120);
		test_pause_until_drained(60);
		test_random(100);
		pos.valid <= 1'b0;
		wait_drained();
		repeat (LATENCY + 10) @(posedge clk);
		if (mismatch_count == 0 && basis_queue.size() == 0) begin
			$display("look_at_rotation_matrix_top test passed");
		end else begin
			if (basis_queue.size() != 0)
				$display("%0t: %0d results never arrived", $time, basis_queue.size());
			$display("look_at_rotation_matrix_top test failed");
		end
		$finish;
	end

endmodule
